@@ sv/cre_pkg.sv @@
// Shared types and constants for the changed run extractor.
package cre_pkg;

	localparam int NET_W      = 4;
	localparam int START_W    = 20;
	localparam int BYTES_W    = 10;
	localparam int VAL_W      = 32;
	localparam int SEEN_W     = 20;
	localparam int RUN_W      = 10;
	localparam int POS_W      = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = 2;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_BYTE = 2'd1,
		MODE_WORD = 2'd2
	} cre_mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_NETWORK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WATCH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

	typedef struct packed {
		logic [VAL_W-1:0] live_value;
		logic [VAL_W-1:0] shadow_value;
		logic             last_element;
	} cre_in_t;

	typedef struct packed {
		logic [NET_W-1:0]   network;
		logic [START_W-1:0] range_start;
		logic [BYTES_W-1:0] range_bytes;
		logic               final_of_input;
	} cre_out_t;

	// One pending report: element position (base plus end index), scale and run length.
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             word;
		logic [RUN_W-1:0] run;
	} cre_rec_t;

	// One queue entry: every report caused by one item.
	typedef struct packed {
		logic [NET_W-1:0] net;
		logic             two;
		cre_rec_t         rec0;
		cre_rec_t         rec1;
	} cre_entry_t;

endpackage

@@ sv/cre_front.sv @@
// Front part: configuration registers, change detection and run bookkeeping.
module cre_front #(
	parameter int MAX_RUN_BYTES = 1024,
	parameter int NETWORKS      = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [cre_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cre_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              accept,
	input  cre_pkg::cre_in_t                  item,
	output logic                              push,
	output cre_pkg::cre_entry_t               entry
);

	localparam int LIM_BITS = $clog2(MAX_RUN_BYTES) + 1;
	localparam int LW = (LIM_BITS > cre_pkg::RUN_W) ? LIM_BITS : cre_pkg::RUN_W;
	localparam logic [LW-1:0] LIM_BYTE = LW'(MAX_RUN_BYTES - 1);
	localparam logic [LW-1:0] LIM_WORD = LW'(MAX_RUN_BYTES / 4 - 1);

	logic [cre_pkg::NET_W-1:0]   net_q;
	logic [cre_pkg::START_W-1:0] watch_q;
	logic [1:0]                  mode_q;
	logic [cre_pkg::SEEN_W-1:0]  seen_q;
	logic [cre_pkg::RUN_W-1:0]   run_q;

	logic                        is_byte;
	logic                        is_word;
	logic                        active;
	logic                        changed;
	logic [cre_pkg::START_W-1:0] base;
	logic [LW-1:0]               limit;
	logic                        close;
	logic                        emit_ok;
	logic [cre_pkg::RUN_W-1:0]   run_mid;
	logic [cre_pkg::RUN_W-1:0]   run_new;
	logic [cre_pkg::SEEN_W-1:0]  seen_new;
	logic                        c0;
	logic                        c1;
	cre_pkg::cre_rec_t           rec_close;
	cre_pkg::cre_rec_t           rec_flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_q   <= '0;
			watch_q <= '0;
			mode_q  <= cre_pkg::MODE_WORD;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cre_pkg::CFG_NETWORK: net_q   <= cfg_data[cre_pkg::NET_W-1:0];
				cre_pkg::CFG_WATCH:   watch_q <= cfg_data[cre_pkg::START_W-1:0];
				cre_pkg::CFG_MODE:    mode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		is_byte  = (mode_q == cre_pkg::MODE_BYTE);
		is_word  = (mode_q == cre_pkg::MODE_WORD);
		active   = is_byte || is_word;
		changed  = is_byte ? (item.live_value[7:0] != item.shadow_value[7:0])
		                   : (item.live_value != item.shadow_value);
		base     = is_byte ? watch_q : {2'b00, watch_q[cre_pkg::START_W-1:2]};
		limit    = is_byte ? LIM_BYTE : LIM_WORD;
		close    = (LW'(run_q) == limit) || (!changed && (run_q != '0));
		emit_ok  = int'(net_q) < NETWORKS;
		run_mid  = close ? '0 : run_q;
		run_new  = changed ? cre_pkg::RUN_W'(run_mid + 1'b1) : run_mid;
		seen_new = cre_pkg::SEEN_W'(seen_q + 1'b1);

		// Close report ends before this element; flush report includes it.
		rec_close.pos  = cre_pkg::POS_W'(base) + cre_pkg::POS_W'(seen_q);
		rec_close.word = is_word;
		rec_close.run  = run_q;
		rec_flush.pos  = cre_pkg::POS_W'(base) + cre_pkg::POS_W'(seen_new);
		rec_flush.word = is_word;
		rec_flush.run  = run_new;

		c0 = active && close && emit_ok;
		c1 = active && item.last_element && (run_new != '0) && emit_ok;

		entry.net  = net_q;
		entry.two  = c0 && c1;
		entry.rec0 = c0 ? rec_close : rec_flush;
		entry.rec1 = rec_flush;
		push       = accept && (c0 || c1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			run_q  <= '0;
		end else if (accept) begin
			if (item.last_element) begin
				seen_q <= '0;
				run_q  <= '0;
			end else if (active) begin
				seen_q <= seen_new;
				run_q  <= run_new;
			end
		end
	end

endmodule

@@ sv/cre_queue.sv @@
// Short entry queue between the front and back parts.
module cre_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cre_pkg::cre_entry_t din,
	input  logic                pop,
	output cre_pkg::cre_entry_t dout,
	output logic                empty,
	output logic                full
);

	cre_pkg::cre_entry_t         mem_q [cre_pkg::Q_DEPTH];
	logic [cre_pkg::Q_PTR_W-1:0] wr_q;
	logic [cre_pkg::Q_PTR_W-1:0] rd_q;
	logic [cre_pkg::Q_PTR_W:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (cre_pkg::Q_PTR_W + 1)'(cre_pkg::Q_DEPTH));
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= cre_pkg::Q_PTR_W'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= cre_pkg::Q_PTR_W'(rd_q + 1'b1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/cre_back.sv @@
// Back part: one report per cycle unless stalled; starts reduced modulo memory size.
module cre_back #(
	parameter int MEMORY_BYTES = 1048576
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  cre_pkg::cre_entry_t q_entry,
	output logic                pop,
	output logic                run_valid,
	input  logic                run_stall,
	output cre_pkg::cre_out_t   run_item
);

	// Offset that keeps start minus length non-negative before the reduction.
	localparam longint MEM_L  = longint'(MEMORY_BYTES);
	localparam longint BOFF_L = MEM_L * ((64'd4096 + MEM_L - 1) / MEM_L);
	localparam int     DW     = $clog2(64'd8388608 + BOFF_L + MEM_L);
	localparam longint RECIP  = (64'd1 << DW) / MEM_L;
	localparam int     RW     = $clog2(RECIP + 1);
	localparam int     MW     = $clog2(MEM_L + 1);
	localparam logic [DW-1:0] BOFF_D = DW'(BOFF_L);
	localparam logic [DW-1:0] MEM_D  = DW'(MEM_L);
	localparam logic [RW-1:0] RECIP_R = RW'(RECIP);
	localparam logic [MW-1:0] MEM_M   = MW'(MEM_L);

	logic              adv;
	logic              sel_q;
	cre_pkg::cre_rec_t cur;
	logic              last_rec;
	logic              issue;
	logic [22:0]       a_byte;
	logic [11:0]       b_byte;

	logic                        v_s1;
	logic [DW-1:0]               d_s1;
	logic [cre_pkg::BYTES_W-1:0] bytes_s1;
	logic [cre_pkg::NET_W-1:0]   net_s1;
	logic                        fin_s1;

	logic                        v_s2;
	logic [DW-1:0]               d_s2;
	logic [RW-1:0]               q_s2;
	logic [cre_pkg::BYTES_W-1:0] bytes_s2;
	logic [cre_pkg::NET_W-1:0]   net_s2;
	logic                        fin_s2;

	logic                        v_s3;
	logic [DW-1:0]               r0_s3;
	logic [cre_pkg::BYTES_W-1:0] bytes_s3;
	logic [cre_pkg::NET_W-1:0]   net_s3;
	logic                        fin_s3;

	logic [DW+RW-1:0]  prod;
	logic [RW+MW-1:0]  qm;
	logic [DW-1:0]     r_fin;
	logic              ov_q;
	cre_pkg::cre_out_t out_q;

	always_comb begin
		adv      = !(ov_q && run_stall);
		cur      = sel_q ? q_entry.rec1 : q_entry.rec0;
		last_rec = sel_q || !q_entry.two;
		issue    = adv && q_valid;
		pop      = issue && last_rec;
		a_byte   = cur.word ? {cur.pos, 2'b00} : {2'b00, cur.pos};
		b_byte   = cur.word ? {cur.run, 2'b00} : {2'b00, cur.run};
		prod     = DW'(d_s1) * (DW + RW)'(RECIP_R);
		qm       = (RW + MW)'(q_s2) * (RW + MW)'(MEM_M);
		r_fin    = (r0_s3 >= MEM_D) ? (r0_s3 - MEM_D) : r0_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			ov_q  <= 1'b0;
		end else if (adv) begin
			if (issue) begin
				sel_q <= !last_rec;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			ov_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1     <= DW'(a_byte) + BOFF_D - DW'(b_byte);
			bytes_s1 <= b_byte[cre_pkg::BYTES_W-1:0];
			net_s1   <= q_entry.net;
			fin_s1   <= last_rec;

			d_s2     <= d_s1;
			q_s2     <= prod[DW+RW-1:DW];
			bytes_s2 <= bytes_s1;
			net_s2   <= net_s1;
			fin_s2   <= fin_s1;

			r0_s3    <= d_s2 - DW'(qm);
			bytes_s3 <= bytes_s2;
			net_s3   <= net_s2;
			fin_s3   <= fin_s2;

			out_q.network        <= net_s3;
			out_q.range_start    <= r_fin[cre_pkg::START_W-1:0];
			out_q.range_bytes    <= bytes_s3;
			out_q.final_of_input <= fin_s3;
		end
	end

	assign run_valid = ov_q;
	assign run_item  = out_q;

endmodule

@@ sv/changed_run_extractor.sv @@
// Top level of the changed run extractor: front, queue and back wired together.
// Throughput: one item per cycle in while the queue has room; the back emits one report
//   per cycle when run_stall is low, so an item with two reports holds the back for
//   both of them; a four-entry queue absorbs it.
// Reset clears the run state and the queue, and loads the registers with their
//   defaults (network 0, watch start 0, word mode); no clearing pass follows.
module changed_run_extractor #(
	parameter int MAX_RUN_BYTES = 1024,
	parameter int MEMORY_BYTES  = 1048576,
	parameter int NETWORKS      = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           elem_valid,
	output logic                           elem_stall,
	input  cre_pkg::cre_in_t               elem,
	output logic                           run_valid,
	input  logic                           run_stall,
	output cre_pkg::cre_out_t              run_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cre_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                accept;
	logic                push;
	logic                pop;
	logic                q_empty;
	logic                q_full;
	cre_pkg::cre_entry_t push_entry;
	cre_pkg::cre_entry_t head_entry;

	// Registers are plain flops; take a write in any cycle.
	assign cfg_ready = 1'b1;

	// Stall the element stream only when the queue has no room left.
	assign elem_stall = q_full;
	assign accept     = elem_valid && !elem_stall;

	// Classify the element and advance run state as soon as it is accepted.
	cre_front #(
		.MAX_RUN_BYTES (MAX_RUN_BYTES),
		.NETWORKS      (NETWORKS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (elem),
		.push      (push),
		.entry     (push_entry)
	);

	// Hold pending reports so the front keeps going while the output stalls.
	cre_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_entry),
		.pop    (pop),
		.dout   (head_entry),
		.empty  (q_empty),
		.full   (q_full)
	);

	// Compute wrapped start addresses and drive the output register.
	cre_back #(
		.MEMORY_BYTES (MEMORY_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_empty),
		.q_entry   (head_entry),
		.pop       (pop),
		.run_valid (run_valid),
		.run_stall (run_stall),
		.run_item  (run_item)
	);

endmodule

@@ sv/cre_checker.sv @@
// Port-level checker for the changed run extractor and its bind.
module cre_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [cre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [cre_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           run_valid,
	input logic                           run_stall,
	input cre_pkg::cre_out_t              run_item
);

	logic [cre_pkg::NET_W-1:0] net_q;
	logic [1:0]                mode_q;

	// Track the network and mode registers as written through the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_q  <= '0;
			mode_q <= cre_pkg::MODE_WORD;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == cre_pkg::CFG_NETWORK) begin
				net_q <= cfg_data[cre_pkg::NET_W-1:0];
			end
			if (cfg_index == cre_pkg::CFG_MODE) begin
				mode_q <= cfg_data[1:0];
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_stall |=> run_valid && $stable(run_item))
		else $error("stalled item changed or dropped");

	a_net: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> run_item.network == net_q)
		else $error("reported network differs from the configured one");

	a_word: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && mode_q == cre_pkg::MODE_WORD |-> run_item.range_bytes[1:0] == 2'b00)
		else $error("word mode length is not a multiple of four");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != cre_pkg::MODE_BYTE && mode_q != cre_pkg::MODE_WORD |-> !run_valid)
		else $error("report while no resolution mode is set");

endmodule

bind changed_run_extractor cre_checker u_cre_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.run_valid (run_valid),
	.run_stall (run_stall),
	.run_item  (run_item)
);

@@ tb/sv/run_checker.sv @@
// Checker for the changed run extractor: predicts reported ranges and compares them.
`timescale 1ns / 100ps

module run_checker #(
	parameter int MAX_RUN_BYTES = 1024,
	parameter int NETWORKS      = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           elem_valid,
	input  logic                           elem_stall,
	input  cre_pkg::cre_in_t               elem,
	input  logic                           run_valid,
	input  logic                           run_stall,
	input  cre_pkg::cre_out_t              run_item,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [cre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cre_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             outstanding
);

	localparam logic [cre_pkg::RUN_W-1:0] BYTE_LIMIT = cre_pkg::RUN_W'(MAX_RUN_BYTES - 1);
	localparam logic [cre_pkg::RUN_W-1:0] WORD_LIMIT = cre_pkg::RUN_W'(MAX_RUN_BYTES / 4 - 1);

	cre_pkg::cre_out_t            due_ranges[$];
	logic [cre_pkg::NET_W-1:0]    net_r;
	logic [cre_pkg::START_W-1:0]  watch_r;
	logic [1:0]                   mode_r;
	logic [cre_pkg::SEEN_W-1:0]   seen_r;
	logic [cre_pkg::RUN_W-1:0]    run_r;

	task automatic report(input string what, input longint unsigned got,
			input longint unsigned want);
		errors++;
		if (errors <= 40) begin
			$display("%0t run_checker: %s got %0h want %0h", $time, what, got, want);
		end
	endtask

	// Range of the open run, ending just before the current element count.
	function automatic cre_pkg::cre_out_t run_range(input logic word);
		cre_pkg::cre_out_t r;
		logic [cre_pkg::START_W-1:0] base;
		base = word ? {watch_r[cre_pkg::START_W-1:2], 2'b00} : watch_r;
		r.network = net_r;
		if (word) begin
			r.range_start = cre_pkg::START_W'(base + {seen_r, 2'b00} - {run_r, 2'b00});
			r.range_bytes = {run_r[cre_pkg::RUN_W-3:0], 2'b00};
		end else begin
			r.range_start = base + seen_r - run_r;
			r.range_bytes = run_r;
		end
		r.final_of_input = 1'b0;
		return r;
	endfunction

	task automatic scan_element(input cre_pkg::cre_in_t e);
		cre_pkg::cre_out_t found[2];
		int n;
		logic word;
		logic changed;
		logic emit;
		n = 0;
		word = (mode_r == cre_pkg::MODE_WORD);
		if (mode_r != cre_pkg::MODE_BYTE && !word) begin
			if (e.last_element) begin
				seen_r = '0;
				run_r = '0;
			end
			return;
		end
		emit = int'(net_r) < NETWORKS;
		changed = word ? (e.live_value != e.shadow_value)
			: (e.live_value[7:0] != e.shadow_value[7:0]);
		if (run_r == (word ? WORD_LIMIT : BYTE_LIMIT) || (!changed && run_r != '0)) begin
			if (emit) begin
				found[n] = run_range(word);
				n++;
			end
			run_r = '0;
		end
		if (changed) run_r = run_r + 1'b1;
		seen_r = seen_r + 1'b1;
		if (e.last_element) begin
			if (run_r != '0 && emit) begin
				found[n] = run_range(word);
				n++;
			end
			run_r = '0;
			seen_r = '0;
		end
		if (n > 0) found[n-1].final_of_input = 1'b1;
		for (int i = 0; i < n; i++) due_ranges = {due_ranges, found[i]};
	endtask

	task automatic take_range(input cre_pkg::cre_out_t got);
		cre_pkg::cre_out_t want;
		if (due_ranges.size() == 0) begin
			report("range with nothing due", got, 0);
			return;
		end
		want = due_ranges.pop_front();
		if (got.network !== want.network) report("network", got.network, want.network);
		if (got.range_start !== want.range_start)
			report("range_start", got.range_start, want.range_start);
		if (got.range_bytes !== want.range_bytes)
			report("range_bytes", got.range_bytes, want.range_bytes);
		if (got.final_of_input !== want.final_of_input)
			report("final_of_input", got.final_of_input, want.final_of_input);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_r = '0;
			watch_r = '0;
			mode_r = cre_pkg::MODE_WORD;
			seen_r = '0;
			run_r = '0;
			due_ranges.delete();
			outstanding = 0;
			errors = 0;
		end else begin
			if (run_valid && !run_stall) take_range(run_item);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cre_pkg::CFG_NETWORK: net_r = cfg_data[cre_pkg::NET_W-1:0];
					cre_pkg::CFG_WATCH:   watch_r = cfg_data[cre_pkg::START_W-1:0];
					cre_pkg::CFG_MODE:    mode_r = cfg_data[1:0];
					default:              ;
				endcase
			end
			if (elem_valid && !elem_stall) scan_element(elem);
			outstanding = due_ranges.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the changed run extractor testbench: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT  = 300000;
	// Items to send in total, directed phases included.
	localparam int ITEM_TARGET  = 850;
	// Give the pipe time to empty out after the last predicted range is back.
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 150;
	// Index and mode values the block must ignore or treat as "no output".
	localparam logic [cre_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
	localparam logic [1:0]                    MODE_SPARE = 2'd3;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_style_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           elem_valid = 1'b0;
	logic                           elem_stall;
	cre_pkg::cre_in_t               elem = '0;
	logic                           run_valid;
	logic                           run_stall = 1'b0;
	cre_pkg::cre_out_t              run_item;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [cre_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [cre_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int           errors;
	int           outstanding;
	int           cycle_count = 0;
	int           burst_left = 0;
	bit           no_gaps = 1'b0;
	bit           hold_req = 1'b0;
	int           hold_left = 0;
	stall_style_t stall_style = STALL_NONE;
	int           style_left = 0;
	int           sent_items = 0;

	changed_run_extractor uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.elem       (elem),
		.run_valid  (run_valid),
		.run_stall  (run_stall),
		.run_item   (run_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	run_checker run_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.elem_valid  (elem_valid),
		.elem_stall  (elem_stall),
		.elem        (elem),
		.run_valid   (run_valid),
		.run_stall   (run_stall),
		.run_item    (run_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop: covers hangs and results that never show up.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Receiver: switch between stall styles at random intervals. A hold request
	// from the stimulus side turns into a long solid stall, counted down here.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (style_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 3));
			style_left = $urandom_range(16, 96);
		end
		style_left--;
		if (hold_left > 0) begin
			hold_left--;
			run_stall <= 1'b1;
		end else begin
			case (stall_style)
				STALL_NONE:  run_stall <= 1'b0;
				STALL_LIGHT: run_stall <= ($urandom_range(0, 7) == 0);
				STALL_HEAVY: run_stall <= 1'($urandom_range(0, 1));
				default:     run_stall <= (style_left % 3 == 0);
			endcase
		end
	end

	function automatic cre_pkg::cre_in_t item(input logic [31:0] live,
			input logic [31:0] shadow, input logic last);
		cre_pkg::cre_in_t x;
		x.live_value = live;
		x.shadow_value = shadow;
		x.last_element = last;
		return x;
	endfunction

	// Random element, changed with the given percentage. With byte_seen set the
	// change always reaches the low byte, so it counts in byte mode too.
	function automatic cre_pkg::cre_in_t scan_item(input int pct_changed, input bit last,
			input bit byte_seen);
		logic [31:0] live;
		logic [31:0] diff;
		case ($urandom_range(0, 7))
			0:       live = '0;
			1:       live = '1;
			default: live = $urandom;
		endcase
		diff = '0;
		if ($urandom_range(0, 99) < pct_changed) begin
			case (byte_seen ? 0 : $urandom_range(0, 2))
				0: diff = {24'($urandom), 8'($urandom_range(1, 255))};
				1: diff = {24'($urandom_range(1, 24'hFFFFFF)), 8'h00};
				default: diff = $urandom | (32'h1 << $urandom_range(0, 31));
			endcase
		end
		return item(live, live ^ diff, last);
	endfunction

	// Offer one item and hold it until taken. Gaps go in between bursts only.
	task automatic push_element(input cre_pkg::cre_in_t x);
		if (!no_gaps && burst_left <= 0) begin
			elem_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 12);
		end
		elem_valid <= 1'b1;
		elem <= x;
		@(posedge clk);
		while (elem_stall) @(posedge clk);
		burst_left--;
		sent_items++;
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write of a group.
	task automatic write_reg(input logic [cre_pkg::CFG_IDX_W-1:0] idx,
			input logic [cre_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Drop valid, wait until every predicted range is back, then let the pipe
	// finish items that report nothing.
	task automatic settle();
		elem_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase;
		int scans;
		int span;
		int pct;
		bit cut;
		logic [cre_pkg::NET_W-1:0] net;
		logic [cre_pkg::START_W-1:0] watch;
		logic [1:0] mode;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults after reset: word mode, network 0, watch start 0.
		// Open, close on unchanged, then flush on the last element.
		push_element(item('1, '0, 1'b0));
		push_element(item('0, '0, 1'b0));
		push_element(item('1, 32'hFFFF_FFFE, 1'b1));
		settle();

		// Top network, watch start at the top of memory so the range runs past its end.
		write_reg(cre_pkg::CFG_NETWORK, 20'hABCDF);
		write_reg(cre_pkg::CFG_WATCH, 20'hFFFFF);
		write_reg(cre_pkg::CFG_MODE, 20'(cre_pkg::MODE_WORD));
		cfg_valid <= 1'b0;
		push_element(item('0, 32'h1, 1'b0));
		push_element(item(32'h8000_0000, '0, 1'b1));
		settle();

		// Byte mode: upper bytes must be ignored; junk in the upper data bits too.
		write_reg(cre_pkg::CFG_WATCH, 20'hFFFFE);
		write_reg(cre_pkg::CFG_MODE, {18'h3FFFF, cre_pkg::MODE_BYTE});
		cfg_valid <= 1'b0;
		push_element(item(32'hFF, '0, 1'b0));
		push_element(item(32'hABCD_EF12, 32'h12, 1'b0));
		push_element(item(32'h1, '0, 1'b0));
		push_element(item(32'h2, 32'h3, 1'b1));
		settle();

		// Mode none, then the spare mode value: nothing reported.
		write_reg(cre_pkg::CFG_MODE, 20'(cre_pkg::MODE_NONE));
		cfg_valid <= 1'b0;
		push_element(item(32'h1, '0, 1'b0));
		push_element(item(32'h2, '0, 1'b0));
		push_element(item(32'h3, '0, 1'b1));
		settle();
		write_reg(cre_pkg::CFG_MODE, 20'(MODE_SPARE));
		write_reg(CFG_SPARE, '1);
		cfg_valid <= 1'b0;
		push_element(item('1, '0, 1'b0));
		push_element(item('0, '1, 1'b1));
		settle();

		// Mode switch mid scan: the run opened in word mode survives an ignored
		// element in mode none and is closed once word mode is back.
		write_reg(cre_pkg::CFG_MODE, 20'(cre_pkg::MODE_WORD));
		write_reg(cre_pkg::CFG_NETWORK, '0);
		cfg_valid <= 1'b0;
		push_element(item(32'h5, 32'h4, 1'b0));
		settle();
		write_reg(cre_pkg::CFG_MODE, 20'(cre_pkg::MODE_NONE));
		cfg_valid <= 1'b0;
		push_element(item(32'h5, 32'h4, 1'b0));
		settle();
		write_reg(cre_pkg::CFG_MODE, 20'(cre_pkg::MODE_WORD));
		cfg_valid <= 1'b0;
		push_element(item(32'h9, 32'h9, 1'b1));

		// Random phases. Each one starts idle, rewrites some registers and sends a
		// few scans; a scan may be cut short so the next settings land mid scan.
		phase = 0;
		while (sent_items < ITEM_TARGET || phase < 4) begin
			settle();
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0:       net = '0;
					1:       net = '1;
					default: net = cre_pkg::NET_W'($urandom);
				endcase
				write_reg(cre_pkg::CFG_NETWORK, {16'($urandom), net});
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 5))
					0:       watch = '0;
					1:       watch = '1;
					2:       watch = 20'hFFFFC;
					3:       watch = 20'h3;
					default: watch = cre_pkg::START_W'($urandom);
				endcase
				write_reg(cre_pkg::CFG_WATCH, watch);
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 19))
					0, 1:                mode = cre_pkg::MODE_NONE;
					2:                   mode = MODE_SPARE;
					3, 4, 5, 6, 7, 8, 9: mode = cre_pkg::MODE_BYTE;
					default:             mode = cre_pkg::MODE_WORD;
				endcase
				write_reg(cre_pkg::CFG_MODE, {18'($urandom), mode});
			end
			if ($urandom_range(0, 19) == 0) write_reg(CFG_SPARE, 20'($urandom));
			// Directed phases pin the mode they start in.
			if (phase == 1 || phase == 2)
				write_reg(cre_pkg::CFG_MODE, 20'(cre_pkg::MODE_WORD));
			if (phase == 3)
				write_reg(cre_pkg::CFG_MODE, 20'(cre_pkg::MODE_BYTE));
			cfg_valid <= 1'b0;

			case (phase)
				1: begin
					// Word run hits the limit; the next element is changed and last,
					// so one item closes the full run and flushes a fresh one.
					repeat (255) push_element(scan_item(100, 1'b0, 1'b0));
					push_element(scan_item(100, 1'b1, 1'b0));
				end
				2: begin
					// Long hold-off on the output while items keep coming back to
					// back: reports pile up and the input must stall.
					no_gaps = 1'b1;
					hold_req = 1'b1;
					for (int k = 0; k < 60; k++)
						push_element(scan_item((k % 2 == 0) ? 100 : 0, k == 59, 1'b1));
					no_gaps = 1'b0;
				end
				3: begin
					// Byte run longer than a word length can carry, taken into word
					// mode, where its length no longer fits and gets truncated.
					repeat (260) push_element(scan_item(100, 1'b0, 1'b1));
					settle();
					write_reg(cre_pkg::CFG_MODE, 20'(cre_pkg::MODE_WORD));
					cfg_valid <= 1'b0;
					push_element(scan_item(100, 1'b0, 1'b1));
					push_element(scan_item(0, 1'b1, 1'b1));
				end
				default: begin
					scans = $urandom_range(1, 6);
					for (int s = 0; s < scans; s++) begin
						span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
							: $urandom_range(1, 16);
						case ($urandom_range(0, 4))
							0:       pct = 0;
							1:       pct = 30;
							2:       pct = 60;
							3:       pct = 90;
							default: pct = 100;
						endcase
						cut = (s == scans - 1) && ($urandom_range(0, 3) == 0);
						for (int k = 0; k < span; k++) begin
							// Stray last flags now and then break a scan early.
							push_element(scan_item(pct,
								(k == span - 1 && !cut) || $urandom_range(0, 49) == 0,
								$urandom_range(0, 1)));
						end
					end
				end
			endcase
			phase++;
		end

		settle();
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/cre_pkg.sv
sv/cre_front.sv
sv/cre_queue.sv
sv/cre_back.sv
sv/changed_run_extractor.sv
sv/cre_checker.sv
tb/sv/run_checker.sv
tb/sv/testbench.sv
